// ----- src/masked_moving_average_assert.svh -----
// Assertion macros shared by the masked moving average RTL.
`ifndef MASKED_MOVING_AVERAGE_ASSERT_SVH
`define MASKED_MOVING_AVERAGE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while in reset.
`define MMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, disabled while in reset.
`define MMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define MMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/mma_pkg.sv -----
// Package: constants and controller/datapath interface types.
package mma_pkg;

    localparam int WINDOW_MAX   = 16;
    localparam int WINDOW_RESET = 8;
    localparam int SAMPLE_W     = 16;
    localparam int WIN_W        = $clog2(WINDOW_MAX + 1);
    localparam int POS_W        = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW_MAX) + 1;
    localparam int DIV_STEPS    = SUM_W;
    localparam int DCNT_W       = $clog2(DIV_STEPS);
    localparam int OP_W         = 2;

    // Operation codes; the high bit alone selects a clear.
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_EMPTY = 2'd1;
    localparam int              OP_CLEAR_BIT = 1;

    typedef struct packed {
        logic cfg_we;     // window length write
        logic push;       // accepted push item
        logic clear;      // accepted clear item
        logic walk;       // accumulate one slot
        logic div_start;  // load divider from sum
        logic div_step;   // one quotient bit
        logic load_out;   // move result into output register
    } mma_cmd_t;

    typedef struct packed {
        logic walk_last;
        logic div_last;
    } mma_status_t;

endpackage

// ----- src/mma_dp.sv -----
// Datapath: sample ring, valid bits, window walk, serial divider, output register.
`include "masked_moving_average_assert.svh"
module mma_dp
    import mma_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  mma_cmd_t                   cmd,
    output mma_status_t                status,
    input  logic [OP_W-1:0]            op,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [WIN_W-1:0]           cfg_data,
    output logic signed [SAMPLE_W-1:0] avg_out,
    output logic                       flag_out
);

    logic signed [SAMPLE_W-1:0] slot_reg [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]      valid_reg, valid_next;
    logic [WIN_W-1:0]           wl_reg, wl_next;
    logic [POS_W-1:0]           wp_reg, wp_next;
    logic [POS_W-1:0]           idx_reg, idx_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [WIN_W-1:0]           cnt_reg, cnt_next;
    logic [SUM_W-1:0]           dq_reg, dq_next;
    logic [WIN_W-1:0]           rem_reg, rem_next;
    logic [DCNT_W-1:0]          dcnt_reg, dcnt_next;
    logic                       neg_reg, neg_next;
    logic                       clr_reg, clr_next;
    logic                       seen_reg, seen_next;
    logic signed [SAMPLE_W-1:0] avg_reg, avg_next;
    logic                       flag_reg, flag_next;

    logic [POS_W-1:0]           pos;
    logic [WIN_W-1:0]           pos_inc;
    logic [WIN_W-1:0]           cfg_clamped;
    logic [WIN_W:0]             rem_sh;
    logic                       ge;
    logic [SAMPLE_W-1:0]        q_mag;

    always_comb begin
        if (cfg_data == '0) begin
            cfg_clamped = WIN_W'(1);
        end else if (cfg_data > WIN_W'(WINDOW_MAX)) begin
            cfg_clamped = WIN_W'(WINDOW_MAX);
        end else begin
            cfg_clamped = cfg_data;
        end
    end

    // A shrunk window may leave the write position outside it.
    assign pos     = ({1'b0, wp_reg} >= wl_reg) ? '0 : wp_reg;
    assign pos_inc = {1'b0, pos} + WIN_W'(1);

    // Restoring divide step: remainder stays below the count.
    assign rem_sh = {rem_reg, dq_reg[SUM_W-1]};
    assign ge     = (rem_sh >= {1'b0, cnt_reg});
    assign q_mag  = dq_reg[SAMPLE_W-1:0];

    always_comb begin
        valid_next = valid_reg;
        wl_next    = wl_reg;
        wp_next    = wp_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        dcnt_next  = dcnt_reg;
        neg_next   = neg_reg;
        clr_next   = clr_reg;
        seen_next  = seen_reg;
        avg_next   = avg_reg;
        flag_next  = flag_reg;

        if (cmd.cfg_we) begin
            wl_next = cfg_clamped;
            wp_next = '0;
        end
        if (cmd.clear) begin
            valid_next = '0;
            clr_next   = 1'b1;
        end
        if (cmd.push) begin
            valid_next[pos] = (op == OP_PUSH);
            wp_next  = (pos_inc == wl_reg) ? '0 : pos_inc[POS_W-1:0];
            clr_next = 1'b0;
            idx_next = '0;
            sum_next = '0;
            cnt_next = '0;
        end
        if (cmd.walk) begin
            if (valid_reg[idx_reg]) begin
                sum_next = sum_reg + SUM_W'(slot_reg[idx_reg]);
                cnt_next = cnt_reg + WIN_W'(1);
            end
            idx_next = idx_reg + POS_W'(1);
        end
        if (cmd.div_start) begin
            neg_next  = sum_reg[SUM_W-1];
            dq_next   = sum_reg[SUM_W-1] ? (~sum_reg + SUM_W'(1)) : sum_reg;
            rem_next  = '0;
            dcnt_next = DCNT_W'(DIV_STEPS - 1);
        end
        if (cmd.div_step) begin
            rem_next  = ge ? WIN_W'(rem_sh - {1'b0, cnt_reg}) : rem_sh[WIN_W-1:0];
            dq_next   = {dq_reg[SUM_W-2:0], ge};
            dcnt_next = dcnt_reg - DCNT_W'(1);
        end
        if (cmd.load_out) begin
            if (clr_reg || (cnt_reg == '0)) begin
                avg_next = '0;
            end else begin
                avg_next = neg_reg ? SAMPLE_W'(-q_mag) : q_mag;
            end
            if (clr_reg) begin
                flag_next = seen_reg;
            end else begin
                seen_next = (cnt_reg != '0);
                flag_next = (cnt_reg != '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            wl_reg    <= WIN_W'(WINDOW_RESET);
            wp_reg    <= '0;
            seen_reg  <= 1'b0;
            clr_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            wl_reg    <= wl_next;
            wp_reg    <= wp_next;
            seen_reg  <= seen_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push && (op == OP_PUSH)) begin
            slot_reg[pos] <= sample;
        end
        idx_reg  <= idx_next;
        sum_reg  <= sum_next;
        cnt_reg  <= cnt_next;
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        dcnt_reg <= dcnt_next;
        neg_reg  <= neg_next;
        avg_reg  <= avg_next;
        flag_reg <= flag_next;
    end

    assign status.walk_last = ({1'b0, idx_reg} == (wl_reg - WIN_W'(1)));
    assign status.div_last  = (dcnt_reg == '0);
    assign avg_out  = avg_reg;
    assign flag_out = flag_reg;

    `MMA_ASSERT_IMP(a_walk_in_window, aclk, aresetn, cmd.walk, {1'b0, idx_reg} < wl_reg)
    `MMA_ASSERT_NXT(a_clear_empties, aclk, aresetn, cmd.clear, valid_reg == '0)
    `MMA_ASSERT_IMP(a_rem_below_cnt, aclk, aresetn, cmd.div_step && (cnt_reg != '0),
                    rem_reg < cnt_reg)

endmodule

// ----- src/mma_ctrl.sv -----
// Controller: sequences accept, window walk, divide and result hand-off.
`include "masked_moving_average_assert.svh"
module mma_ctrl
    import mma_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        op_clear,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    output mma_cmd_t    cmd,
    input  mma_status_t status
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WALK  = 3'd1;
    localparam logic [2:0] ST_DINIT = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       s_acc;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign s_acc     = s_tvalid && s_tready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        cmd.cfg_we   = cfg_valid && cfg_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    cmd.clear  = op_clear;
                    cmd.push   = !op_clear;
                    state_next = op_clear ? ST_OUT : ST_WALK;
                end
            end
            ST_WALK: begin
                cmd.walk = 1'b1;
                if (status.walk_last) begin
                    state_next = ST_DINIT;
                end
            end
            ST_DINIT: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

    `MMA_ASSERT_NXT(a_accept_leaves_idle, aclk, aresetn, s_acc, state_reg != ST_IDLE)
    `MMA_ASSERT_NXT(a_load_shows_item, aclk, aresetn, cmd.load_out, m_valid_reg)
    `MMA_ASSERT_IMP(a_one_phase, aclk, aresetn, 1'b1,
                    $onehot0({cmd.walk, cmd.div_start, cmd.div_step, cmd.load_out}))

endmodule

// ----- src/masked_moving_average.sv -----
// Top level: masked moving average over a ring of up to sixteen signed samples.
// Each input item is one operation (tuser): push a sample, push an empty slot,
// or clear (high bit set) which empties every slot. A push writes the slot at
// the write position, advances it modulo the window length, then walks the
// first window_length slots one per cycle summing the valid ones, and divides
// the sum by the valid count with a restoring divider, one quotient bit per
// cycle. The result is truncated toward zero; with no valid slot the average
// is 0 and the flag is low. A clear answers average 0 with the flag as left
// by the previous push. One item is in work at a time: a push walks the
// window, divides and then loads the result register, while a clear goes
// straight to the result register. The output register lets a finished item
// wait for m_tready; the block stalls in its last step only if the previous
// item is still unclaimed. Writing window_length (clamped to 1..16) resets
// the write position but keeps slot contents; it is taken only while idle.
module masked_moving_average
    import mma_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Input items
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // [15:0] sample (signed)
    input  logic [1:0]          s_tuser,   // [1:0] operation
    // Result items
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // [15:0] average (signed)
    output logic                m_tuser,   // [0] has_valid
    // Window length register
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [WIN_W-1:0]    cfg_data   // window_length
);

    mma_cmd_t                   cmd;
    mma_status_t                status;
    logic signed [SAMPLE_W-1:0] avg;

    // Sequencer: owns the handshakes and the output valid.
    mma_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .op_clear  (s_tuser[OP_CLEAR_BIT]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Ring, accumulator, divider and result register.
    mma_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .op       (s_tuser),
        .sample   (s_tdata),
        .cfg_data (cfg_data),
        .avg_out  (avg),
        .flag_out (m_tuser)
    );

    assign m_tdata = avg;

endmodule

// ----- verif/masked_moving_average_checker.sv -----
// Result checker for the masked moving average: tracks the ring, predicts each average and compares.
module masked_moving_average_checker
    import mma_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [15:0]         s_tdata,   // [15:0] sample (signed)
    input  logic [1:0]          s_tuser,   // [1:0] operation
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [15:0]         m_tdata,   // [15:0] average (signed)
    input  logic                m_tuser,   // [0] has_valid
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [WIN_W-1:0]    cfg_data,  // window_length
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic                       has_valid;
    } avg_result_t;

    avg_result_t                avg_expected_q[$];
    logic signed [SAMPLE_W-1:0] ring_sample [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]      ring_full;
    int                         ring_len;
    int                         wr_pos;
    logic                       any_valid;
    int                         mismatches = 0;

    function automatic int clamp_len(input logic [WIN_W-1:0] value);
        if (value == 0) begin
            return 1;
        end
        if (value > WINDOW_MAX) begin
            return WINDOW_MAX;
        end
        return int'(value);
    endfunction

    // Applies one operation to the tracked ring and returns the average it should give.
    function automatic avg_result_t predict_average(input logic [1:0] op,
                                                    input logic signed [SAMPLE_W-1:0] smp);
        avg_result_t r;
        int          total;
        int          used;
        total = 0;
        used  = 0;
        if (op[OP_CLEAR_BIT]) begin
            // clear empties every slot, flag stays as the last push left it
            ring_full   = '0;
            r.average   = '0;
            r.has_valid = any_valid;
            return r;
        end
        if (wr_pos >= ring_len) begin
            wr_pos = 0;
        end
        if (op == OP_PUSH) begin
            ring_sample[wr_pos] = smp;
            ring_full[wr_pos]   = 1'b1;
        end else begin
            ring_full[wr_pos] = 1'b0;
        end
        wr_pos = (wr_pos + 1) % ring_len;
        for (int i = 0; i < ring_len; i++) begin
            if (ring_full[i]) begin
                total += ring_sample[i];
                used++;
            end
        end
        any_valid   = (used > 0);
        r.has_valid = any_valid;
        if (used > 0) begin
            r.average = SAMPLE_W'(total / used);   // int division truncates toward zero
        end else begin
            r.average = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        avg_result_t want;
        if (!aresetn) begin
            avg_expected_q.delete();
            ring_full = '0;
            ring_len  = WINDOW_RESET;
            wr_pos    = 0;
            any_valid = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (avg_expected_q.size() == 0) begin
                    report_mismatch($sformatf("result with no item waiting, average %0d",
                                              $signed(m_tdata)));
                end else begin
                    want = avg_expected_q.pop_front();
                    if (m_tdata !== want.average) begin
                        report_mismatch($sformatf("average got %0d, expected %0d",
                                                  $signed(m_tdata), want.average));
                    end
                    if (m_tuser !== want.has_valid) begin
                        report_mismatch($sformatf("has_valid got %b, expected %b",
                                                  m_tuser, want.has_valid));
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                ring_len = clamp_len(cfg_data);
                wr_pos   = 0;
            end
            if (s_tvalid && s_tready) begin
                avg_expected_q.push_back(predict_average(s_tuser, s_tdata));
            end
        end
        fail_count <= mismatches;
        pending    <= avg_expected_q.size();
    end

endmodule

// ----- verif/testbench.sv -----
// Top of the masked moving average testbench: clock, reset, stimulus, idling and verdict.
module testbench
    import mma_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // clear is any code with the high bit set; 3 is the spare code that decodes as clear
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 128;
    localparam int SETTLE_CYCLES = 48;    // longer than the longest push
    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off, block must back up
    localparam int HOLD_PHASE    = 4;
    localparam int QUIET_LIMIT   = 4000;  // cycles with no item moving on any channel

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [15:0]      s_tdata;
    logic [1:0]       s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [15:0]      m_tdata;
    logic             m_tuser;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [WIN_W-1:0] cfg_data;

    int               error_count;
    int               pending_results;
    idle_mode_t       idle_mode;
    bit               hold_armed;
    bit               hold_done;
    int               hold_count;
    int               quiet_cycles;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    masked_moving_average u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    masked_moving_average_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (error_count),
        .pending    (pending_results)
    );

    function automatic bit sender_pauses();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 64;
            IDLE_BOTH:   return $urandom_range(0, 99) < 36;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < 64;
            IDLE_BOTH:     return $urandom_range(0, 99) < 36;
            default:       return 1'b0;
        endcase
    endfunction

    // Mostly pushes, so windows fill up between clears.
    function automatic logic [1:0] rand_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 72) begin
            return OP_PUSH;
        end else if (roll < 87) begin
            return OP_EMPTY;
        end else if (roll < 96) begin
            return OP_CLEAR;
        end
        return OP_SPARE;
    endfunction

    // Extremes, small values (rounding toward zero) and full-range noise.
    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            1:       return 16'($signed($urandom_range(0, 16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // Presents one item and returns at the edge where it is taken.
    task automatic send_item(input logic [1:0] op, input logic [15:0] smp);
        @(negedge aclk);
        while (sender_pauses()) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drops valid, waits for every result and lets the block go quiet.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] value);
        settle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls per idle mode, plus one long hold-off counted here.
    initial begin
        m_tready   = 1'b0;
        hold_done  = 1'b0;
        hold_count = 0;
        forever begin
            @(negedge aclk);
            if (hold_armed && !hold_done) begin
                m_tready <= 1'b0;
                hold_count++;
                if (hold_count >= HOLD_CYCLES) begin
                    hold_done = 1'b1;
                end
            end else begin
                m_tready <= !receiver_stalls();
            end
        end
    end

    // Watchdog: any item moving on any channel resets the count.
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                    || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [WIN_W-1:0] window_plan [PHASES];
        logic [WIN_W-1:0] win;

        // 0 and 31 are clamped; 17 is just above the maximum
        window_plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd4, 5'd17,
                        5'd8, 5'd2, 5'd0, 5'd12, 5'd3, 5'd0};

        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = OP_PUSH;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        idle_mode  = IDLE_NONE;
        hold_armed = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed run at the reset window of 8
        send_item(OP_CLEAR, 16'h0000);   // clear with nothing ever valid
        send_item(OP_EMPTY, 16'hFFFF);   // empty push, no valid slot: 0 and flag low
        send_item(OP_PUSH,  16'h7FFF);
        send_item(OP_PUSH,  16'h7FFF);
        send_item(OP_PUSH,  16'h8000);
        send_item(OP_PUSH,  16'hFFFF);
        send_item(OP_PUSH,  16'h0000);
        send_item(OP_PUSH,  16'hFFFD);
        send_item(OP_PUSH,  16'hFFFC);
        send_item(OP_PUSH,  16'h8000);   // window full
        send_item(OP_EMPTY, 16'h1234);   // empties slot 1
        send_item(OP_PUSH,  16'h7FFF);
        send_item(OP_SPARE, 16'hFFFF);   // spare code acts as clear, flag kept high
        send_item(OP_EMPTY, 16'h0000);   // all empty again: flag drops
        send_item(OP_CLEAR, 16'hAAAA);   // clear with flag low
        send_item(OP_PUSH,  16'hFFF9);   // -7
        send_item(OP_PUSH,  16'h0002);   // -5 / 2 truncates to -2
        send_item(OP_PUSH,  16'h0007);
        send_item(OP_PUSH,  16'hFFFE);   // 0 / 4
        send_item(OP_EMPTY, 16'h5555);
        send_item(OP_PUSH,  16'h0001);

        for (int p = 0; p < PHASES; p++) begin
            win = window_plan[p];
            if (p == 8 || p == PHASES - 1) begin
                win = WIN_W'($urandom);
            end
            write_window(win);
            idle_mode = idle_mode_t'(p % 4);
            if (p == HOLD_PHASE) begin
                hold_armed = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(rand_op(), rand_sample());
            end
        end

        settle();
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
